// File: rtl/bae_pkg.sv
package bae_pkg;

  localparam int unsigned CodeW = 32;
  localparam int unsigned MaxResults = 20;
  localparam int unsigned ResCntW = $clog2(MaxResults + 1);

  localparam logic [CodeW-1:0] Half = 32'h8000_0000;
  localparam logic [CodeW-1:0] Quarter = 32'h4000_0000;
  localparam logic [CodeW-1:0] ThreeQuarter = 32'hC000_0000;
  localparam logic [CodeW-1:0] AllOnes = ~32'h0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_NORM,
    ST_FLUSH
  } state_e;

endpackage

// File: rtl/binary_arithmetic_encoder.sv
// Channel | Direction | Handshake                          | Payload
// input   | in        | in_valid_i / in_stall_o            | command_i data_bit_i weight_*_i
// output  | out       | out_valid_o / out_stall_i          | code_bit_o follow_count_o last_o
//         |           |                                    | stream_end_o
// Encode item: a load, the bit-serial shift-add multiply, the restoring divide and an update step,
// then renormalization doublings until the interval straddles the middle again;
// the multiply and divide scale the range by weight_zero over the sum of both weights.
// One item is in work at a time.
// Reset sets the interval to full and clears the pending count at once.
// A stalled output holds renormalization only when a result has to move.
module binary_arithmetic_encoder #(
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic                             data_bit_i,
  input  logic [WEIGHT_BITS-1:0]           weight_zero_i,
  input  logic [WEIGHT_BITS-1:0]           weight_one_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             code_bit_o,
  output logic [bae_pkg::CodeW-1:0]        follow_count_o,
  output logic                             last_o,
  output logic                             stream_end_o
);

  localparam int unsigned CW = bae_pkg::CodeW;
  localparam int unsigned RangeW = CW + 1;
  localparam int unsigned ProdW = RangeW + WEIGHT_BITS;
  localparam int unsigned DivW = WEIGHT_BITS + 1;
  localparam int unsigned CntW = $clog2((CW > WEIGHT_BITS) ? CW : WEIGHT_BITS);

  bae_pkg::state_e state_q, state_d;

  logic [CW-1:0]          low_q, high_q, pending_q;
  logic [RangeW-1:0]      range_q;
  logic [WEIGHT_BITS-1:0] wz_q;
  logic [DivW-1:0]        div_q;
  logic [ProdW-1:0]       acc_q;
  logic [DivW-1:0]        rem_q;
  logic [CW-1:0]          quo_q;
  logic [CntW-1:0]        cnt_q;
  logic                   bit_q;
  logic                   hold_v_q, hold_bit_q;
  logic [CW-1:0]          hold_follow_q;
  logic [bae_pkg::ResCntW-1:0] res_cnt_q;
  logic                   out_valid_q, out_bit_q, out_last_q, out_end_q;
  logic [CW-1:0]          out_follow_q;

  logic                   in_acc, out_free;
  logic [WEIGHT_BITS-1:0] wz_fix, wo_fix;
  logic [ProdW-1:0]       acc_d;
  logic [DivW:0]          div_t, div_diff;
  logic                   div_ge;
  logic                   emit, mid_case, brk, store, norm_go, flush_go, push;
  logic [CW-1:0]          low_m, high_m;
  logic                   mul_done, div_done;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign wz_fix = (weight_zero_i == '0) ? WEIGHT_BITS'(1) : weight_zero_i;
  assign wo_fix = (weight_one_i == '0) ? WEIGHT_BITS'(1) : weight_one_i;

  assign acc_d = {acc_q[ProdW-2:0], 1'b0}
               + (wz_q[WEIGHT_BITS-1] ? ProdW'(range_q) : ProdW'(0));

  assign div_t = {rem_q, quo_q[CW-1]};
  assign div_diff = div_t - {1'b0, div_q};
  assign div_ge = (div_t >= {1'b0, div_q});

  assign mul_done = (cnt_q == CntW'(WEIGHT_BITS - 1));
  assign div_done = (cnt_q == CntW'(CW - 1));

  assign emit = !high_q[CW-1] || low_q[CW-1];
  assign mid_case = (low_q[CW-1:CW-2] == 2'b01) && (high_q[CW-1:CW-2] == 2'b10);
  assign brk = !emit && !mid_case;
  assign store = emit && (res_cnt_q < bae_pkg::ResCntW'(bae_pkg::MaxResults));

  assign low_m = emit ? low_q : (low_q & ~bae_pkg::Quarter);
  assign high_m = emit ? high_q : (high_q | bae_pkg::Quarter);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bae_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = command_i ? bae_pkg::ST_FLUSH : bae_pkg::ST_MUL;
        end
      end
      bae_pkg::ST_MUL: begin
        if (mul_done) begin
          state_d = bae_pkg::ST_DIV;
        end
      end
      bae_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = bae_pkg::ST_APPLY;
        end
      end
      bae_pkg::ST_APPLY: state_d = bae_pkg::ST_NORM;
      bae_pkg::ST_NORM: begin
        if (norm_go && brk) begin
          state_d = bae_pkg::ST_IDLE;
        end
      end
      bae_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_d = bae_pkg::ST_IDLE;
        end
      end
      default: state_d = bae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    norm_go = 1'b0;
    flush_go = 1'b0;
    push = 1'b0;
    case (state_q)
      bae_pkg::ST_IDLE: in_stall_o = 1'b0;
      bae_pkg::ST_NORM: begin
        norm_go = !(hold_v_q && (store || brk)) || out_free;
        push = norm_go && hold_v_q && (store || brk);
      end
      bae_pkg::ST_FLUSH: flush_go = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bae_pkg::ST_IDLE;
      low_q <= '0;
      high_q <= bae_pkg::AllOnes;
      pending_q <= '0;
      hold_v_q <= 1'b0;
      res_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // hold the result register until it is taken
      if (push || flush_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        bae_pkg::ST_APPLY: begin
          if (bit_q) begin
            low_q <= low_q + quo_q;
          end else begin
            high_q <= low_q + quo_q - CW'(1);
          end
          res_cnt_q <= '0;
        end
        bae_pkg::ST_NORM: begin
          if (norm_go) begin
            if (brk) begin
              hold_v_q <= 1'b0;
            end else begin
              low_q <= {low_m[CW-2:0], 1'b0};
              high_q <= {high_m[CW-2:0], 1'b1};
              if (emit) begin
                pending_q <= '0;
                if (store) begin
                  hold_v_q <= 1'b1;
                  res_cnt_q <= res_cnt_q + bae_pkg::ResCntW'(1);
                end
              end else if (pending_q != bae_pkg::AllOnes) begin
                pending_q <= pending_q + CW'(1);
              end
            end
          end
        end
        bae_pkg::ST_FLUSH: begin
          if (flush_go) begin
            low_q <= '0;
            high_q <= bae_pkg::AllOnes;
            pending_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_bit_q <= hold_bit_q;
      out_follow_q <= hold_follow_q;
      out_last_q <= brk;
      out_end_q <= 1'b0;
    end else if (flush_go) begin
      out_bit_q <= |low_q[CW-1:CW-2];
      out_follow_q <= CW'(1);
      out_last_q <= 1'b1;
      out_end_q <= 1'b1;
    end

    if (norm_go && store) begin
      hold_bit_q <= low_q[CW-1];
      hold_follow_q <= pending_q;
    end

    case (state_q)
      bae_pkg::ST_IDLE: begin
        if (in_acc) begin
          bit_q <= data_bit_i;
          wz_q <= wz_fix;
          div_q <= {1'b0, wz_fix} + {1'b0, wo_fix};
          range_q <= {1'b0, high_q} - {1'b0, low_q} + RangeW'(1);
          acc_q <= '0;
          cnt_q <= '0;
        end
      end
      bae_pkg::ST_MUL: begin
        acc_q <= acc_d;
        wz_q <= {wz_q[WEIGHT_BITS-2:0], 1'b0};
        if (mul_done) begin
          rem_q <= acc_d[ProdW-1:CW];
          quo_q <= acc_d[CW-1:0];
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      bae_pkg::ST_DIV: begin
        rem_q <= div_ge ? div_diff[DivW-1:0] : div_t[DivW-1:0];
        quo_q <= {quo_q[CW-2:0], div_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign code_bit_o = out_bit_q;
  assign follow_count_o = out_follow_q;
  assign last_o = out_last_q;
  assign stream_end_o = out_end_q;

  a_idle_straddles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bae_pkg::ST_IDLE) |-> (!low_q[CW-1] && high_q[CW-1]))
    else $error("interval does not straddle the middle while idle");

  a_hold_in_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (state_q == bae_pkg::ST_NORM))
    else $error("held result outside renormalization");

  a_res_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= bae_pkg::ResCntW'(bae_pkg::MaxResults))
    else $error("result count beyond limit");

  a_flush_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i) |=> (state_q == bae_pkg::ST_FLUSH))
    else $error("flush item did not enter flush");

endmodule
